// File: hdl/ula_pkg.sv
// ----------------------------------------------------------------------------
// ula_pkg: shared definitions of the receive line assembler
// Store geometry, status codes, character codes and the memory request type.
// ----------------------------------------------------------------------------
package ula_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int CAP_W        = 7;
	localparam int LEN_W        = 6;
	localparam int CMP_W        = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_LIMIT = 7'd64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_DROPPED   = 3'd1;
	localparam logic [2:0] ST_NO_LINE   = 3'd2;
	localparam logic [2:0] ST_COMPLETE  = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam logic MODE_PUSH    = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic [7:0] NL_CHAR = 8'h0A;
	localparam logic [7:0] CR_CHAR = 8'h0D;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} ula_mem_req_t;

endpackage

// File: hdl/ula_in_if.sv
// ----------------------------------------------------------------------------
// ula_in_if: input channel of the receive line assembler
// Carries one push or extract request per beat.
// ----------------------------------------------------------------------------
interface ula_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// File: hdl/ula_out_if.sv
// ----------------------------------------------------------------------------
// ula_out_if: result channel of the receive line assembler
// Carries one status beat or one line character per beat.
// ----------------------------------------------------------------------------
interface ula_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        byte_valid;
	logic [7:0]  line_byte;
	logic        last;
	logic [5:0]  line_length;
	logic [15:0] overflow_count;

	modport source (output valid, output status, output byte_valid, output line_byte,
		output last, output line_length, output overflow_count, input ready);
	modport sink   (input valid, input status, input byte_valid, input line_byte,
		input last, input line_length, input overflow_count, output ready);
endinterface

// File: hdl/ula_store.sv
// ----------------------------------------------------------------------------
// ula_store: character store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ula_store import ula_pkg::*; (
	input  logic         clk,
	input  ula_mem_req_t req,
	output logic [7:0]   rd_data_q
);

	logic [7:0] mem_q [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem_q[req.rd_addr];
	end

endmodule

// File: hdl/ula_ctrl.sv
// ----------------------------------------------------------------------------
// ula_ctrl: sequencer of the receive line assembler
// Pushes bytes, scans for a newline with one shared compare, streams the
// line and compacts the store through its one read and one write port.
// ----------------------------------------------------------------------------
module ula_ctrl import ula_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] cap,
	ula_in_if.sink           item,
	ula_out_if.source        result,
	output ula_mem_req_t     mem_req,
	input  logic [7:0]       rd_data
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ONE     = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_EMIT    = 3'd3;
	localparam logic [2:0] S_COMPACT = 3'd4;

	logic [2:0]       state_q, next_q;
	logic [CNT_W-1:0] fill_q, idx_q, src_q, dst_q;
	logic [15:0]      drop_q;
	logic             prev_cr_q, rd_pend_q;
	logic [LEN_W-1:0] emit_q, k_q, len_q;
	logic [2:0]       status_q;

	logic             out_valid_q, o_bv_q, o_last_q;
	logic [2:0]       o_status_q;
	logic [7:0]       o_byte_q;
	logic [LEN_W-1:0] o_len_q;
	logic [15:0]      o_ovf_q;

	logic             accept, out_free, out_load, is_full, complete;
	logic [CAP_W-1:0] cap_eff;
	logic [CNT_W-1:0] line_end;
	logic [LEN_W-1:0] emit_n, len_n;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign out_load   = out_free && (state_q == S_ONE || state_q == S_EMIT);
	assign is_full    = (fill_q >= CNT_W'(BUFFER_DEPTH));
	assign cap_eff    = (cap > CAP_LIMIT) ? CAP_LIMIT : cap;

	// A carriage return right before the newline is not part of the line.
	assign line_end = idx_q - CNT_W'(prev_cr_q);
	assign complete = (CMP_W'(line_end) < CMP_W'(cap_eff));
	assign emit_n   = complete ? LEN_W'(line_end) : LEN_W'(cap_eff - 7'd1);
	assign len_n    = complete ? LEN_W'(line_end) : '0;

	assign result.valid          = out_valid_q;
	assign result.status         = o_status_q;
	assign result.byte_valid     = o_bv_q;
	assign result.line_byte      = o_byte_q;
	assign result.last           = o_last_q;
	assign result.line_length    = o_len_q;
	assign result.overflow_count = o_ovf_q;

	always_comb begin
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = fill_q[ADDR_W-1:0];
		mem_req.wr_data = item.rx_byte;
		mem_req.rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				mem_req.wr_en = accept && (item.mode == MODE_PUSH) && !is_full;
			end
			S_SCAN: begin
				// Once the newline is seen, fetch the first line byte for emission.
				mem_req.rd_addr = (rd_data == NL_CHAR) ? '0 : ADDR_W'(idx_q + CNT_W'(1));
			end
			S_EMIT: begin
				mem_req.rd_addr = out_free ? ADDR_W'(k_q + 6'd1) : ADDR_W'(k_q);
			end
			S_COMPACT: begin
				mem_req.wr_en   = rd_pend_q;
				mem_req.wr_addr = dst_q[ADDR_W-1:0];
				mem_req.wr_data = rd_data;
				mem_req.rd_addr = src_q[ADDR_W-1:0];
			end
			default: begin
				mem_req.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_q      <= S_IDLE;
			fill_q      <= '0;
			drop_q      <= '0;
			idx_q       <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			prev_cr_q   <= 1'b0;
			rd_pend_q   <= 1'b0;
			emit_q      <= '0;
			k_q         <= '0;
			len_q       <= '0;
			status_q    <= ST_ACCEPTED;
			out_valid_q <= 1'b0;
			o_bv_q      <= 1'b0;
			o_last_q    <= 1'b0;
			o_status_q  <= ST_ACCEPTED;
			o_byte_q    <= '0;
			o_len_q     <= '0;
			o_ovf_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						prev_cr_q <= 1'b0;
						len_q     <= '0;
						next_q    <= S_IDLE;
						if (item.mode == MODE_PUSH) begin
							if (is_full) begin
								drop_q   <= drop_q + 16'd1;
								status_q <= ST_DROPPED;
							end else begin
								fill_q   <= fill_q + CNT_W'(1);
								status_q <= ST_ACCEPTED;
							end
							state_q <= S_ONE;
						end else if (cap_eff == '0 || fill_q == '0) begin
							status_q <= ST_NO_LINE;
							state_q  <= S_ONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_data == NL_CHAR) begin
						status_q  <= complete ? ST_COMPLETE : ST_TRUNCATED;
						len_q     <= len_n;
						emit_q    <= emit_n;
						k_q       <= '0;
						src_q     <= idx_q + CNT_W'(1);
						dst_q     <= '0;
						rd_pend_q <= 1'b0;
						next_q    <= S_COMPACT;
						state_q   <= (emit_n == '0) ? S_ONE : S_EMIT;
					end else if (idx_q + CNT_W'(1) == fill_q) begin
						status_q <= ST_NO_LINE;
						next_q   <= S_IDLE;
						state_q  <= S_ONE;
					end else begin
						idx_q     <= idx_q + CNT_W'(1);
						prev_cr_q <= (rd_data == CR_CHAR);
					end
				end
				S_ONE: begin
					if (out_free) begin
						o_status_q  <= status_q;
						o_bv_q      <= 1'b0;
						o_byte_q    <= '0;
						o_last_q    <= 1'b1;
						o_len_q     <= len_q;
						o_ovf_q     <= drop_q;
						state_q     <= next_q;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						o_status_q  <= status_q;
						o_bv_q      <= 1'b1;
						o_byte_q    <= rd_data;
						o_last_q    <= (k_q + 6'd1 == emit_q);
						o_len_q     <= len_q;
						o_ovf_q     <= drop_q;
						k_q         <= k_q + 6'd1;
						if (k_q + 6'd1 == emit_q) begin
							state_q <= S_COMPACT;
						end
					end
				end
				S_COMPACT: begin
					if (rd_pend_q) begin
						dst_q <= dst_q + CNT_W'(1);
					end
					if (src_q < fill_q) begin
						src_q     <= src_q + CNT_W'(1);
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (!rd_pend_q) begin
							fill_q  <= dst_q;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/uart_line_assembler.sv
// ----------------------------------------------------------------------------
// uart_line_assembler: receive line buffer for a serial link
// Push: the result goes from the sequencer's result step into the output register.
// A new beat is taken only after the result step of the last one, which waits on the sink.
// Extract: scan to the newline, then emit the line characters, then compact the
// rest of the store, all through the store's one read and one write port.
// Reset: fill count and drop counter clear, capacity returns to 64; no clearing pass.
// ----------------------------------------------------------------------------
module uart_line_assembler import ula_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	ula_in_if.sink           item,
	ula_out_if.source        result
);

	// The capacity register counts the terminator, so a capacity of n lets
	// at most n-1 characters through. Values above 64 act as 64 inside the
	// sequencer, and zero makes every extract report that no line is there.
	logic [CAP_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// The sequencer owns both store ports: during a push it writes the byte
	// at the fill position, during a scan it reads one entry per cycle into the
	// newline compare, during emission it reads the line in order, and during
	// compaction it reads the tail and writes it in the next cycle at the front.
	ula_mem_req_t mem_req;
	logic [7:0]   rd_data;

	ula_store u_store (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data)
	);

	// Every result beat passes through an output register in the sequencer,
	// so a new input beat can be taken while the previous result waits.
	ula_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap     (cap_q),
		.item    (item),
		.result  (result),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// The block leaves its idle state right after it takes an input beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input still ready after an accepted beat");

	// While idle, the store is written only by the push that is accepted now.
	a_idle_write_is_push: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.wr_en && item.ready) |-> (item.valid && item.mode == MODE_PUSH))
		else $error("store written while idle without a push beat");

	// A result beat that waits for the sink stays on offer unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.status)
			&& $stable(result.line_byte) && $stable(result.last)))
		else $error("waiting result beat changed or was withdrawn");

endmodule
